// ===== rtl/core/i2cee_pkg.sv =====
// ---------------------------------------------------------------------------
// I2C EEPROM transfer master package
// Shared widths, operation codes, register indexes and word types.
// ---------------------------------------------------------------------------
package i2cee_pkg;

   // Field widths.
   localparam int OP_W       = 2;
   localparam int BYTE_W     = 8;
   localparam int SUBADDR_W  = 16;
   localparam int LEN_W      = 5;
   localparam int ABYTES_W   = 2;
   localparam int RETRY_W    = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // Operation codes carried by a request word.
   localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH     = 2'd1;
   localparam logic [OP_W-1:0] OP_BEGIN_WR = 2'd2;
   localparam logic [OP_W-1:0] OP_BEGIN_RD = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS_BYTES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT    = 2'd2;

   // Configuration reset values.
   localparam logic [BYTE_W-1:0]   DEVICE_ADDRESS_RST = 8'hA0;
   localparam logic [ABYTES_W-1:0] ADDRESS_BYTES_RST  = 2'd1;
   localparam logic [RETRY_W-1:0]  RETRY_LIMIT_RST    = 10'd1000;

   typedef logic [LEN_W-1:0] len_type;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic                 sda_in;
      logic [SUBADDR_W-1:0] sub_address;
      logic [LEN_W-1:0]     transfer_length;
      logic [BYTE_W-1:0]    data_byte;
   } req_word_type;

   typedef struct packed {
      logic              scl_out;
      logic              sda_out;
      logic [BYTE_W-1:0] read_byte;
      logic              read_valid;
      logic              last_byte;
      logic              busy_res;
      logic              done_res;
      logic              address_timeout;
   } rsp_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   device_address;
      logic [ABYTES_W-1:0] address_bytes;
      logic [RETRY_W-1:0]  retry_limit;
   } cfg_type;

   // Controls from the bus sequencer to the write queue.
   typedef struct packed {
      logic push;
      logic clear;
   } queue_ctl_type;

endpackage

// ===== rtl/core/i2cee_channels.sv =====
// ---------------------------------------------------------------------------
// I2C EEPROM transfer master channels
// Valid/ready channel interfaces for request words and response words.
// ---------------------------------------------------------------------------
interface i2cee_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [i2cee_pkg::OP_W-1:0]             op;
   logic                                   sda_in;
   logic [i2cee_pkg::SUBADDR_W-1:0]        sub_address;
   logic [i2cee_pkg::LEN_W-1:0]            transfer_length;
   logic [i2cee_pkg::BYTE_W-1:0]           data_byte;

   modport source (output valid, op, sda_in, sub_address, transfer_length, data_byte,
                   input ready);
   modport sink (input valid, op, sda_in, sub_address, transfer_length, data_byte,
                 output ready);
endinterface

interface i2cee_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          scl_out;
   logic                          sda_out;
   logic [i2cee_pkg::BYTE_W-1:0]  read_byte;
   logic                          read_valid;
   logic                          last_byte;
   logic                          busy_res;
   logic                          done_res;
   logic                          address_timeout;

   modport source (output valid, scl_out, sda_out, read_byte, read_valid, last_byte,
                   busy_res, done_res, address_timeout, input ready);
   modport sink (input valid, scl_out, sda_out, read_byte, read_valid, last_byte,
                 busy_res, done_res, address_timeout, output ready);
endinterface

// ===== rtl/core/i2cee_queue.sv =====
// ---------------------------------------------------------------------------
// I2C EEPROM write queue
// Page buffer for bytes to be written, with a fill count and a registered
// read port that prefetches the next data byte for the sequencer.
// ---------------------------------------------------------------------------
module i2cee_queue #(
   parameter int PAGE_BYTES = 16,
   parameter int AW         = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  i2cee_pkg::queue_ctl_type      ctl,
   input  logic [i2cee_pkg::BYTE_W-1:0]  wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [i2cee_pkg::BYTE_W-1:0]  rd_data
);

   localparam int CW = $clog2(PAGE_BYTES + 1);

   logic [i2cee_pkg::BYTE_W-1:0] mem [PAGE_BYTES];
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic                         wr_en;
   logic [i2cee_pkg::BYTE_W-1:0] rd_data_ff;

   // A byte is stored only while the page still has room.
   assign wr_en = en && ctl.push && (count_ff < CW'(PAGE_BYTES));

   // Fill count; a begin-write hands the queue over to the transfer.
   always_comb begin
      count_in = count_ff;
      if (en && ctl.clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Storage and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= wr_data;
      end
      if (en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/i2cee_ctrl.sv =====
// ---------------------------------------------------------------------------
// I2C EEPROM bus sequencer
// Quarter-bit state machine that drives SCL and SDA for START, address,
// sub-address, data, repeated START, receive and STOP phases.
// ---------------------------------------------------------------------------
module i2cee_ctrl #(
   parameter int PAGE_BYTES = 16,
   parameter int AW         = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  i2cee_pkg::req_word_type       req,
   input  i2cee_pkg::cfg_type            cfg,
   input  logic [i2cee_pkg::BYTE_W-1:0]  rd_data,
   output i2cee_pkg::rsp_word_type       res,
   output i2cee_pkg::queue_ctl_type      queue_ctl,
   output logic [AW-1:0]                 rd_addr
);

   // Phase codes.
   localparam logic [3:0] P_IDLE   = 4'd0;
   localparam logic [3:0] P_START  = 4'd1;
   localparam logic [3:0] P_DEV    = 4'd2;
   localparam logic [3:0] P_SUB    = 4'd3;
   localparam logic [3:0] P_DATA   = 4'd4;
   localparam logic [3:0] P_RSTART = 4'd5;
   localparam logic [3:0] P_DEVR   = 4'd6;
   localparam logic [3:0] P_RECV   = 4'd7;
   localparam logic [3:0] P_STOP   = 4'd8;

   localparam int LW = i2cee_pkg::LEN_W;

   logic                          scl_ff, scl_in;
   logic                          sda_ff, sda_in;
   logic [3:0]                    phase_ff, phase_in;
   logic [1:0]                    qtr_ff, qtr_in;
   logic [3:0]                    bit_ff, bit_in;
   logic [7:0]                    shift_ff, shift_in;
   logic [LW-1:0]                 bd_ff, bd_in;
   logic [1:0]                    abl_ff, abl_in;
   logic [i2cee_pkg::RETRY_W-1:0] retry_ff, retry_in;
   logic [15:0]                   addr_ff, addr_in;
   logic [LW-1:0]                 len_ff, len_in;
   logic                          rmode_ff, rmode_in;
   logic                          tout_ff, tout_in;

   logic [LW:0]   bd_inc;
   logic          last_recv;
   logic [LW-1:0] bd_arg;
   logic [1:0]    abl_arg;
   logic [3:0]    dat_phase, sub_phase, rcv_phase;
   logic [7:0]    dat_shift, sub_shift;
   logic          nak;
   logic [LW:0]   rd_sum;

   // Targets of the helper transitions taken when a byte completes.
   always_comb begin
      bd_inc    = {1'b0, bd_ff} + {{LW{1'b0}}, 1'b1};
      last_recv = bd_inc >= {1'b0, len_ff};
      bd_arg    = ((phase_ff == P_DATA) || (phase_ff == P_RECV)) ? bd_inc[LW-1:0] : bd_ff;
      abl_arg   = (phase_ff == P_SUB) ? (abl_ff - 2'd1) : abl_ff;
      nak       = shift_ff[0];

      if (bd_arg < len_ff) begin
         dat_phase = P_DATA;
         dat_shift = rd_data;
      end else begin
         dat_phase = P_STOP;
         dat_shift = '0;
      end

      if (abl_arg != 2'd0) begin
         sub_phase = P_SUB;
         sub_shift = (abl_arg >= 2'd2) ? addr_ff[15:8] : addr_ff[7:0];
      end else if (rmode_ff) begin
         sub_phase = P_RSTART;
         sub_shift = '0;
      end else begin
         sub_phase = dat_phase;
         sub_shift = dat_shift;
      end

      rcv_phase = (bd_arg < len_ff) ? P_RECV : P_STOP;
   end

   // Next state and response for one request word.
   always_comb begin
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      phase_in  = phase_ff;
      qtr_in    = qtr_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      bd_in     = bd_ff;
      abl_in    = abl_ff;
      retry_in  = retry_ff;
      addr_in   = addr_ff;
      len_in    = len_ff;
      rmode_in  = rmode_ff;
      tout_in   = tout_ff;
      queue_ctl = '0;
      res       = '0;

      if (req.op == i2cee_pkg::OP_TICK) begin
         if (phase_ff != P_IDLE) begin
            qtr_in = qtr_ff + 2'd1;
         end
         unique case (phase_ff)
            P_START, P_RSTART: begin
               unique case (qtr_ff)
                  2'd0: sda_in = 1'b1;
                  2'd1: scl_in = 1'b1;
                  2'd2: sda_in = 1'b0;
                  default: begin
                     scl_in   = 1'b0;
                     phase_in = (phase_ff == P_START) ? P_DEV : P_DEVR;
                     shift_in = (phase_ff == P_START) ? (cfg.device_address & 8'hFE)
                                                      : (cfg.device_address | 8'h01);
                     bit_in   = '0;
                     qtr_in   = '0;
                  end
               endcase
            end
            P_STOP: begin
               unique case (qtr_ff)
                  2'd0: sda_in = 1'b0;
                  2'd1: scl_in = 1'b1;
                  2'd2: sda_in = 1'b1;
                  default: begin
                     phase_in     = P_IDLE;
                     qtr_in       = '0;
                     res.done_res = 1'b1;
                  end
               endcase
            end
            P_RECV: begin
               unique case (qtr_ff)
                  2'd0: sda_in = (bit_ff < 4'd8) ? 1'b1 : last_recv;
                  2'd1: scl_in = 1'b1;
                  2'd2: begin
                     if (bit_ff < 4'd8) begin
                        shift_in = {shift_ff[6:0], req.sda_in};
                     end
                  end
                  default: begin
                     scl_in = 1'b0;
                     if (bit_ff >= 4'd8) begin
                        // Byte received and acknowledged.
                        res.read_byte  = shift_ff;
                        res.read_valid = 1'b1;
                        res.last_byte  = last_recv;
                        bd_in          = bd_arg;
                        phase_in       = rcv_phase;
                        shift_in       = '0;
                        bit_in         = '0;
                        qtr_in         = '0;
                     end else begin
                        bit_in = bit_ff + 4'd1;
                     end
                  end
               endcase
            end
            P_DEV, P_SUB, P_DATA, P_DEVR: begin
               unique case (qtr_ff)
                  2'd0: sda_in = (bit_ff < 4'd8) ? shift_ff[~bit_ff[2:0]] : 1'b1;
                  2'd1: scl_in = 1'b1;
                  2'd2: begin
                     if (bit_ff >= 4'd8) begin
                        shift_in = {7'd0, req.sda_in};
                     end
                  end
                  default: begin
                     scl_in = 1'b0;
                     if (bit_ff >= 4'd8) begin
                        // Byte sent; pick the next phase.
                        bit_in = '0;
                        qtr_in = '0;
                        if (phase_ff == P_DEV) begin
                           if (!rmode_ff && nak && (retry_ff > 10'd1)) begin
                              retry_in = retry_ff - 10'd1;
                              phase_in = P_START;
                              shift_in = '0;
                           end else begin
                              if (!rmode_ff && nak) begin
                                 retry_in = '0;
                                 tout_in  = 1'b1;
                              end
                              phase_in = sub_phase;
                              shift_in = sub_shift;
                           end
                        end else if (phase_ff == P_SUB) begin
                           abl_in   = abl_arg;
                           phase_in = sub_phase;
                           shift_in = sub_shift;
                        end else if (phase_ff == P_DATA) begin
                           bd_in    = bd_arg;
                           phase_in = dat_phase;
                           shift_in = dat_shift;
                        end else begin
                           phase_in = rcv_phase;
                           shift_in = '0;
                        end
                     end else begin
                        bit_in = bit_ff + 4'd1;
                     end
                  end
               endcase
            end
            default: ;
         endcase
      end else if (phase_ff == P_IDLE) begin
         if (req.op == i2cee_pkg::OP_PUSH) begin
            queue_ctl.push = 1'b1;
         end else begin
            // Begin a transfer.
            rmode_in        = (req.op == i2cee_pkg::OP_BEGIN_RD);
            queue_ctl.clear = (req.op == i2cee_pkg::OP_BEGIN_WR);
            addr_in         = req.sub_address;
            len_in          = (32'(req.transfer_length) > PAGE_BYTES)
                              ? i2cee_pkg::len_type'(PAGE_BYTES) : req.transfer_length;
            abl_in          = (cfg.address_bytes > 2'd2) ? 2'd2 : cfg.address_bytes;
            retry_in        = (cfg.retry_limit == '0) ? 10'd1 : cfg.retry_limit;
            bd_in           = '0;
            tout_in         = 1'b0;
            phase_in        = P_START;
            shift_in        = '0;
            bit_in          = '0;
            qtr_in          = '0;
         end
      end

      res.scl_out         = scl_in;
      res.sda_out         = sda_in;
      res.busy_res        = (phase_in != P_IDLE);
      res.address_timeout = tout_in;
   end

   // Prefetch the queue entry the next data byte will need.
   assign rd_sum  = (phase_in == P_DATA) ? ({1'b0, bd_in} + {{LW{1'b0}}, 1'b1})
                                         : {1'b0, bd_in};
   assign rd_addr = AW'(rd_sum);

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         phase_ff <= P_IDLE;
         qtr_ff   <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         bd_ff    <= '0;
         abl_ff   <= '0;
         retry_ff <= '0;
         addr_ff  <= '0;
         len_ff   <= '0;
         rmode_ff <= 1'b0;
         tout_ff  <= 1'b0;
      end else if (en) begin
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         phase_ff <= phase_in;
         qtr_ff   <= qtr_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         bd_ff    <= bd_in;
         abl_ff   <= abl_in;
         retry_ff <= retry_in;
         addr_ff  <= addr_in;
         len_ff   <= len_in;
         rmode_ff <= rmode_in;
         tout_ff  <= tout_in;
      end
   end

   // Checks.
   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      en && res.done_res |=> phase_ff == P_IDLE)
      else $error("STOP finished but sequencer not idle");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(phase_ff) && $stable(qtr_ff) && $stable(bd_ff))
      else $error("sequencer state moved without a word");

   a_read_only_in_read: assert property (@(posedge clock) disable iff (reset)
      en && res.read_valid |-> rmode_ff)
      else $error("received byte outside a read transfer");

   a_timeout_write_only: assert property (@(posedge clock) disable iff (reset)
      tout_ff |-> !rmode_ff)
      else $error("address timeout flagged in a read transfer");

   a_bytes_in_range: assert property (@(posedge clock) disable iff (reset)
      en |=> bd_ff <= len_ff)
      else $error("byte count passed the transfer length");

endmodule

// ===== rtl/core/i2c_eeprom_transfer_master.sv =====
// ---------------------------------------------------------------------------
// I2C EEPROM transfer master
// Bit-level I2C master for EEPROM page writes and sequential reads.
// ---------------------------------------------------------------------------
// Usage: each request word is either a tick, which advances the bus by one
// quarter bit and samples sda_in, or a command (queue a write byte, begin a
// write, begin a read). Commands are taken only while no transfer runs;
// otherwise they are dropped and leave the bus untouched. Every request word
// yields exactly one response word with the SCL/SDA levels to drive, any
// received byte, and busy, done and address-timeout status.
// Registers: a request word, once accepted, passes through one input register
// and one response register before its response word is offered.
// Throughput: one word per cycle while rsp_ch is ready; the sequencer updates
// its state once per word, so the quarter-bit state machine sets the rate.
// Reset: the lines are released high, the sequencer is idle, the write
// queue is empty and the configuration registers take their defaults.
// Stalls: when rsp_ch is not ready, the response register holds its word and
// one more request word waits in the input register before req_ch.ready drops.
// The user must write configuration via the csr_ port while idle; unchecked.
// ---------------------------------------------------------------------------
module i2c_eeprom_transfer_master #(
   parameter int PAGE_BYTES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   i2cee_req_if.sink                           req_ch,
   i2cee_rsp_if.source                         rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [i2cee_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [i2cee_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

   logic                      in_valid_ff, in_valid_in;
   i2cee_pkg::req_word_type   in_word_ff;
   logic                      out_valid_ff, out_valid_in;
   i2cee_pkg::rsp_word_type   out_word_ff;
   i2cee_pkg::rsp_word_type   res;
   i2cee_pkg::cfg_type        cfg_ff;
   i2cee_pkg::queue_ctl_type  queue_ctl;
   logic [i2cee_pkg::BYTE_W-1:0] rd_data;
   logic [AW-1:0]             rd_addr;
   logic                      accept;
   logic                      advance;

   // Handshake: a word moves forward when the response register is free.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input and response payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff.op              <= req_ch.op;
         in_word_ff.sda_in          <= req_ch.sda_in;
         in_word_ff.sub_address     <= req_ch.sub_address;
         in_word_ff.transfer_length <= req_ch.transfer_length;
         in_word_ff.data_byte       <= req_ch.data_byte;
      end
      if (advance) begin
         out_word_ff <= res;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= i2cee_pkg::DEVICE_ADDRESS_RST;
         cfg_ff.address_bytes  <= i2cee_pkg::ADDRESS_BYTES_RST;
         cfg_ff.retry_limit    <= i2cee_pkg::RETRY_LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            i2cee_pkg::CSR_DEVICE_ADDRESS: cfg_ff.device_address <= csr_wdata[7:0];
            i2cee_pkg::CSR_ADDRESS_BYTES:  cfg_ff.address_bytes  <= csr_wdata[1:0];
            i2cee_pkg::CSR_RETRY_LIMIT:    cfg_ff.retry_limit    <= csr_wdata;
            default: ;
         endcase
      end
   end

   i2cee_ctrl #(
      .PAGE_BYTES (PAGE_BYTES),
      .AW         (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .req       (in_word_ff),
      .cfg       (cfg_ff),
      .rd_data   (rd_data),
      .res       (res),
      .queue_ctl (queue_ctl),
      .rd_addr   (rd_addr)
   );

   i2cee_queue #(
      .PAGE_BYTES (PAGE_BYTES),
      .AW         (AW)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .en      (advance),
      .ctl     (queue_ctl),
      .wr_data (in_word_ff.data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Response channel.
   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.scl_out         = out_word_ff.scl_out;
   assign rsp_ch.sda_out         = out_word_ff.sda_out;
   assign rsp_ch.read_byte       = out_word_ff.read_byte;
   assign rsp_ch.read_valid      = out_word_ff.read_valid;
   assign rsp_ch.last_byte       = out_word_ff.last_byte;
   assign rsp_ch.busy_res        = out_word_ff.busy_res;
   assign rsp_ch.done_res        = out_word_ff.done_res;
   assign rsp_ch.address_timeout = out_word_ff.address_timeout;

endmodule

// ===== tb/i2c_eeprom_transfer_master_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// I2C EEPROM transfer master testbench
// Feeds tick and command words into the request channel and checks every
// response word against a cycle-free model of the bus sequencer: line
// levels, received bytes, busy, done and address-timeout status.
// ---------------------------------------------------------------------------
module i2c_eeprom_transfer_master_tb;

   localparam int PAGE_BYTES    = 16;
   localparam int RESET_CYCLES  = 11;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_WORDS  = 850;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [3:0] {
      PH_IDLE, PH_START, PH_DEV, PH_SUB, PH_DATA, PH_RSTART, PH_DEVR, PH_RECV, PH_STOP
   } bus_phase_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_wr_en;
   logic [i2cee_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [i2cee_pkg::CSR_DATA_W-1:0] csr_wdata;

   i2cee_req_if req_ch();
   i2cee_rsp_if rsp_ch();

   i2c_eeprom_transfer_master #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Model copy of the configuration registers.
   logic [i2cee_pkg::BYTE_W-1:0]   m_dev_addr;
   logic [i2cee_pkg::ABYTES_W-1:0] m_addr_bytes;
   logic [i2cee_pkg::RETRY_W-1:0]  m_retry_limit;

   // Model copy of the sequencer state.
   logic                            m_scl;
   logic                            m_sda;
   bus_phase_type                   m_phase;
   logic [1:0]                      m_quarter;
   logic [3:0]                      m_bit;
   logic [i2cee_pkg::BYTE_W-1:0]    m_shift;
   logic [i2cee_pkg::LEN_W-1:0]     m_bytes_done;
   logic [i2cee_pkg::ABYTES_W-1:0]  m_sub_left;
   logic [i2cee_pkg::RETRY_W-1:0]   m_retries;
   logic [i2cee_pkg::BYTE_W-1:0]    m_queue [PAGE_BYTES];
   logic [i2cee_pkg::LEN_W-1:0]     m_queue_count;
   int                              m_queue_filled;
   logic [i2cee_pkg::SUBADDR_W-1:0] m_sub_latch;
   logic [i2cee_pkg::LEN_W-1:0]     m_len_latch;
   logic                            m_read_mode;
   logic                            m_timeout;

   // Per-word results of the model.
   logic [i2cee_pkg::BYTE_W-1:0] m_got_byte;
   logic                         m_got_valid;
   logic                         m_got_last;
   logic                         m_got_done;

   // Response words still owed by the block, oldest first.
   i2cee_pkg::rsp_word_type awaited_bus_words[$];

   int  mismatches;
   int  cycle_count;
   int  random_words;
   bit  counting_random;
   bit  steady_flow;
   int  hold_request;
   int  hold_left;
   int  forced_naks;
   int  nak_percent;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Sequencer model
   // ------------------------------------------------------------------------
   function automatic void reset_bus_model();
      m_dev_addr     = i2cee_pkg::DEVICE_ADDRESS_RST;
      m_addr_bytes   = i2cee_pkg::ADDRESS_BYTES_RST;
      m_retry_limit  = i2cee_pkg::RETRY_LIMIT_RST;
      m_scl          = 1'b1;
      m_sda          = 1'b1;
      m_phase        = PH_IDLE;
      m_quarter      = '0;
      m_bit          = '0;
      m_shift        = '0;
      m_bytes_done   = '0;
      m_sub_left     = '0;
      m_retries      = '0;
      m_queue_count  = '0;
      m_queue_filled = 0;
      m_sub_latch    = '0;
      m_len_latch    = '0;
      m_read_mode    = 1'b0;
      m_timeout      = 1'b0;
   endfunction

   function automatic void load_phase(bus_phase_type p,
                                      logic [i2cee_pkg::BYTE_W-1:0] value);
      m_phase   = p;
      m_shift   = value;
      m_bit     = '0;
      m_quarter = '0;
   endfunction

   function automatic void next_receive();
      if (m_bytes_done < m_len_latch) load_phase(PH_RECV, '0);
      else load_phase(PH_STOP, '0);
   endfunction

   function automatic void next_data();
      if (m_bytes_done < m_len_latch && m_bytes_done < PAGE_BYTES) begin
         load_phase(PH_DATA, m_queue[m_bytes_done]);
      end else begin
         load_phase(PH_STOP, '0);
      end
   endfunction

   // Sub-address bytes go out high byte first when two are left.
   function automatic void next_sub_address();
      if (m_sub_left > 0) begin
         load_phase(PH_SUB, (m_sub_left >= 2) ? m_sub_latch[15:8] : m_sub_latch[7:0]);
      end else if (m_read_mode) begin
         load_phase(PH_RSTART, '0);
      end else begin
         next_data();
      end
   endfunction

   // After the acknowledge bit, m_shift holds the sampled SDA level.
   function automatic void finish_byte();
      logic nak;
      nak = m_shift[0];
      case (m_phase)
         PH_DEV: begin
            if (!m_read_mode && nak) begin
               if (m_retries > 1) begin
                  m_retries--;
                  load_phase(PH_START, '0);
                  return;
               end
               m_retries = '0;
               m_timeout = 1'b1;
            end
            next_sub_address();
         end
         PH_SUB: begin
            m_sub_left--;
            next_sub_address();
         end
         PH_DATA: begin
            m_bytes_done++;
            next_data();
         end
         default: next_receive();
      endcase
   endfunction

   // One quarter bit of bus time.
   function automatic void quarter_tick(logic sda);
      logic [1:0] q;
      logic       last;
      q = m_quarter;
      case (m_phase)
         PH_IDLE: return;
         PH_START, PH_RSTART: begin
            if (q == 2'd0) m_sda = 1'b1;
            else if (q == 2'd1) m_scl = 1'b1;
            else if (q == 2'd2) m_sda = 1'b0;
            else begin
               m_scl = 1'b0;
               if (m_phase == PH_START) load_phase(PH_DEV, m_dev_addr & 8'hFE);
               else load_phase(PH_DEVR, m_dev_addr | 8'h01);
               return;
            end
         end
         PH_STOP: begin
            if (q == 2'd0) m_sda = 1'b0;
            else if (q == 2'd1) m_scl = 1'b1;
            else if (q == 2'd2) m_sda = 1'b1;
            else begin
               m_phase    = PH_IDLE;
               m_quarter  = '0;
               m_got_done = 1'b1;
               return;
            end
         end
         PH_RECV: begin
            last = (int'(m_bytes_done) + 1 >= int'(m_len_latch));
            if (q == 2'd0) m_sda = (m_bit < 8) ? 1'b1 : last;
            else if (q == 2'd1) m_scl = 1'b1;
            else if (q == 2'd2) begin
               if (m_bit < 8) m_shift = {m_shift[6:0], sda};
            end else begin
               m_scl = 1'b0;
               if (m_bit >= 8) begin
                  m_got_byte  = m_shift;
                  m_got_valid = 1'b1;
                  m_got_last  = last;
                  m_bytes_done++;
                  next_receive();
                  return;
               end
               m_bit++;
            end
         end
         default: begin
            if (q == 2'd0) m_sda = (m_bit < 8) ? m_shift[7 - m_bit] : 1'b1;
            else if (q == 2'd1) m_scl = 1'b1;
            else if (q == 2'd2) begin
               if (m_bit >= 8) m_shift = {7'd0, sda};
            end else begin
               m_scl = 1'b0;
               if (m_bit >= 8) begin
                  finish_byte();
                  return;
               end
               m_bit++;
            end
         end
      endcase
      m_quarter = q + 2'd1;
   endfunction

   // Applies one request word and returns the response word it yields.
   function automatic i2cee_pkg::rsp_word_type step_bus_master(i2cee_pkg::req_word_type w);
      i2cee_pkg::rsp_word_type r;
      m_got_byte  = '0;
      m_got_valid = 1'b0;
      m_got_last  = 1'b0;
      m_got_done  = 1'b0;
      if (w.op == i2cee_pkg::OP_TICK) begin
         quarter_tick(w.sda_in);
      end else if (m_phase == PH_IDLE) begin
         if (w.op == i2cee_pkg::OP_PUSH) begin
            if (m_queue_count < PAGE_BYTES) begin
               m_queue[m_queue_count] = w.data_byte;
               m_queue_count++;
               if (m_queue_count > m_queue_filled) m_queue_filled = m_queue_count;
            end
         end else begin
            m_read_mode = (w.op == i2cee_pkg::OP_BEGIN_RD);
            if (w.op == i2cee_pkg::OP_BEGIN_WR) m_queue_count = '0;
            m_sub_latch  = w.sub_address;
            m_len_latch  = (w.transfer_length > PAGE_BYTES)
                           ? i2cee_pkg::LEN_W'(PAGE_BYTES) : w.transfer_length;
            m_sub_left   = (m_addr_bytes > 2) ? i2cee_pkg::ABYTES_W'(2) : m_addr_bytes;
            m_retries    = (m_retry_limit == 0) ? i2cee_pkg::RETRY_W'(1) : m_retry_limit;
            m_bytes_done = '0;
            m_timeout    = 1'b0;
            load_phase(PH_START, '0);
         end
      end
      r.scl_out         = m_scl;
      r.sda_out         = m_sda;
      r.read_byte       = m_got_byte;
      r.read_valid      = m_got_valid;
      r.last_byte       = m_got_last;
      r.busy_res        = (m_phase != PH_IDLE);
      r.done_res        = m_got_done;
      r.address_timeout = m_timeout;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Word generation
   // ------------------------------------------------------------------------
   function automatic i2cee_pkg::req_word_type random_word(
      input logic [i2cee_pkg::OP_W-1:0] op);
      i2cee_pkg::req_word_type w;
      w.op              = op;
      w.sda_in          = 1'($urandom_range(1));
      w.sub_address     = i2cee_pkg::SUBADDR_W'($urandom());
      w.transfer_length = i2cee_pkg::LEN_W'($urandom());
      w.data_byte       = i2cee_pkg::BYTE_W'($urandom());
      return w;
   endfunction

   function automatic logic [i2cee_pkg::OP_W-1:0] random_command();
      case ($urandom_range(2))
         0:       return i2cee_pkg::OP_PUSH;
         1:       return i2cee_pkg::OP_BEGIN_WR;
         default: return i2cee_pkg::OP_BEGIN_RD;
      endcase
   endfunction

   // The slave's answer on SDA; only the write-address acknowledge is steered.
   function automatic logic pick_line_level();
      if (m_phase == PH_DEV && m_bit == 4'd8) begin
         if (forced_naks > 0) begin
            if (m_quarter == 2'd2) forced_naks--;
            return 1'b1;
         end
         return ($urandom_range(99) < nak_percent);
      end
      return 1'($urandom_range(1));
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   task automatic send_word(input i2cee_pkg::req_word_type w);
      bit ignored;
      if (!steady_flow && $urandom_range(99) < 10) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.op              <= w.op;
      req_ch.sda_in          <= w.sda_in;
      req_ch.sub_address     <= w.sub_address;
      req_ch.transfer_length <= w.transfer_length;
      req_ch.data_byte       <= w.data_byte;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ignored = (w.op == i2cee_pkg::OP_TICK) ? (m_phase == PH_IDLE) : (m_phase != PH_IDLE);
      if (counting_random && !ignored) random_words++;
      awaited_bus_words.push_back(step_bus_master(w));
   endtask

   task automatic wait_for_bus_words();
      req_ch.valid <= 1'b0;
      while (awaited_bus_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [i2cee_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [i2cee_pkg::CSR_DATA_W-1:0] value);
      wait_for_bus_words();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         i2cee_pkg::CSR_DEVICE_ADDRESS: m_dev_addr    = value[i2cee_pkg::BYTE_W-1:0];
         i2cee_pkg::CSR_ADDRESS_BYTES:  m_addr_bytes  = value[i2cee_pkg::ABYTES_W-1:0];
         i2cee_pkg::CSR_RETRY_LIMIT:    m_retry_limit = value[i2cee_pkg::RETRY_W-1:0];
         default: ;
      endcase
   endtask

   task automatic push_byte(input logic [i2cee_pkg::BYTE_W-1:0] value);
      i2cee_pkg::req_word_type w;
      w = random_word(i2cee_pkg::OP_PUSH);
      w.data_byte = value;
      send_word(w);
   endtask

   // Ticks the bus until STOP completes, mixing in stray commands at noise_pct.
   task automatic run_until_idle(input int noise_pct);
      i2cee_pkg::req_word_type w;
      while (m_phase != PH_IDLE) begin
         if ($urandom_range(99) < noise_pct) begin
            w = random_word(random_command());
         end else begin
            w = random_word(i2cee_pkg::OP_TICK);
            w.sda_in = pick_line_level();
         end
         send_word(w);
      end
   endtask

   task automatic run_transfer(input logic [i2cee_pkg::OP_W-1:0] op,
                               input logic [i2cee_pkg::SUBADDR_W-1:0] sub,
                               input logic [i2cee_pkg::LEN_W-1:0] len, input int noise_pct);
      i2cee_pkg::req_word_type w;
      w = random_word(op);
      w.sub_address     = sub;
      w.transfer_length = len;
      send_word(w);
      run_until_idle(noise_pct);
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------
   initial begin
      hold_request = 0;
      hold_left    = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (steady_flow) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 10);
         end
      end
   end

   function automatic void check_field(string name, logic [i2cee_pkg::BYTE_W-1:0] want,
                                       logic [i2cee_pkg::BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Compare each accepted response word with the oldest one owed.
   always @(posedge clock) begin
      i2cee_pkg::rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_bus_words.size() == 0) begin
            $error("response word with nothing outstanding");
            mismatches++;
         end else begin
            want = awaited_bus_words.pop_front();
            check_field("scl_out", want.scl_out, rsp_ch.scl_out);
            check_field("sda_out", want.sda_out, rsp_ch.sda_out);
            check_field("read_byte", want.read_byte, rsp_ch.read_byte);
            check_field("read_valid", want.read_valid, rsp_ch.read_valid);
            check_field("last_byte", want.last_byte, rsp_ch.last_byte);
            check_field("busy_res", want.busy_res, rsp_ch.busy_res);
            check_field("done_res", want.done_res, rsp_ch.done_res);
            check_field("address_timeout", want.address_timeout, rsp_ch.address_timeout);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("run exceeded %0d cycles", CYCLE_LIMIT);
         $display("i2c_eeprom_transfer_master verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Ticks on an idle bus leave both lines released.
   task automatic test_idle_ticks();
      i2cee_pkg::req_word_type w;
      w = random_word(i2cee_pkg::OP_TICK);
      w.sda_in = 1'b0;
      send_word(w);
      w = random_word(i2cee_pkg::OP_TICK);
      w.sda_in          = 1'b1;
      w.sub_address     = '1;
      w.transfer_length = '1;
      w.data_byte       = '1;
      send_word(w);
   endtask

   // Overfill the queue, then write a full page; the extra bytes are dropped.
   task automatic test_page_write();
      push_byte(8'h00);
      push_byte(8'hFF);
      repeat (PAGE_BYTES) push_byte(i2cee_pkg::BYTE_W'($urandom()));
      run_transfer(i2cee_pkg::OP_BEGIN_WR, 16'h1234, i2cee_pkg::LEN_W'(PAGE_BYTES), 0);
   endtask

   // Commands during a transfer are dropped; the next write reuses stored bytes.
   task automatic test_busy_commands();
      push_byte(8'hA5);
      push_byte(8'h5A);
      run_transfer(i2cee_pkg::OP_BEGIN_WR, 16'h00F0, 5'd2, 0);
      push_byte(8'h00);
      send_word(random_word(i2cee_pkg::OP_BEGIN_WR));
      send_word(random_word(i2cee_pkg::OP_BEGIN_RD));
      send_word(random_word(i2cee_pkg::OP_BEGIN_RD));
      run_until_idle(0);
   endtask

   // Sequential reads: short, zero length and an oversized length; then short and zero-length writes.
   task automatic test_reads();
      write_register(i2cee_pkg::CSR_ADDRESS_BYTES, i2cee_pkg::CSR_DATA_W'(2));
      write_register(i2cee_pkg::CSR_DEVICE_ADDRESS, i2cee_pkg::CSR_DATA_W'(8'hFF));
      run_transfer(i2cee_pkg::OP_BEGIN_RD, 16'hFFFF, 5'd3, 0);
      run_transfer(i2cee_pkg::OP_BEGIN_RD, 16'h0000, 5'd0, 0);
      run_transfer(i2cee_pkg::OP_BEGIN_RD, 16'h8001, 5'd31, 0);
      write_register(i2cee_pkg::CSR_DEVICE_ADDRESS, i2cee_pkg::CSR_DATA_W'(8'h00));
      run_transfer(i2cee_pkg::OP_BEGIN_WR, 16'h7FFE, 5'd1, 0);
      run_transfer(i2cee_pkg::OP_BEGIN_WR, 16'h0000, 5'd0, 0);
   endtask

   // No sub-address bytes, and a count of three acting as two.
   task automatic test_address_widths();
      write_register(i2cee_pkg::CSR_ADDRESS_BYTES, i2cee_pkg::CSR_DATA_W'(0));
      run_transfer(i2cee_pkg::OP_BEGIN_WR, 16'hABCD, 5'd1, 0);
      run_transfer(i2cee_pkg::OP_BEGIN_RD, 16'hABCD, 5'd1, 0);
      write_register(i2cee_pkg::CSR_ADDRESS_BYTES, i2cee_pkg::CSR_DATA_W'(3));
      run_transfer(i2cee_pkg::OP_BEGIN_WR, 16'hC35A, 5'd1, 0);
      run_transfer(i2cee_pkg::OP_BEGIN_RD, 16'h3CA5, 5'd2, 0);
   endtask

   // Address NAK handling: limits of zero, two and the maximum.
   task automatic test_address_retries();
      steady_flow = 1'b1;
      write_register(i2cee_pkg::CSR_ADDRESS_BYTES, i2cee_pkg::CSR_DATA_W'(1));
      write_register(i2cee_pkg::CSR_RETRY_LIMIT, i2cee_pkg::CSR_DATA_W'(0));
      forced_naks = 1;
      run_transfer(i2cee_pkg::OP_BEGIN_WR, 16'h0011, 5'd1, 0);
      write_register(i2cee_pkg::CSR_RETRY_LIMIT, i2cee_pkg::CSR_DATA_W'(2));
      forced_naks = 2;
      run_transfer(i2cee_pkg::OP_BEGIN_WR, 16'h0022, 5'd1, 0);
      forced_naks = 1;
      run_transfer(i2cee_pkg::OP_BEGIN_WR, 16'h0033, 5'd1, 0);
      write_register(i2cee_pkg::CSR_RETRY_LIMIT, i2cee_pkg::CSR_DATA_W'(1023));
      forced_naks = 3;
      run_transfer(i2cee_pkg::OP_BEGIN_WR, 16'h0044, 5'd2, 0);
      // A read never retries, whatever the slave answers.
      forced_naks = 1;
      run_transfer(i2cee_pkg::OP_BEGIN_RD, 16'h0055, 5'd1, 0);
      forced_naks = 0;
      steady_flow = 1'b0;
   endtask

   // Receiver stalls long enough to back the block up, then the sender drains.
   task automatic test_back_pressure();
      write_register(i2cee_pkg::CSR_RETRY_LIMIT, i2cee_pkg::CSR_DATA_W'(4));
      nak_percent  = 30;
      hold_request = 80;
      repeat (4) push_byte(i2cee_pkg::BYTE_W'($urandom()));
      run_transfer(i2cee_pkg::OP_BEGIN_WR, i2cee_pkg::SUBADDR_W'($urandom()), 5'd4, 0);
      wait_for_bus_words();
      run_transfer(i2cee_pkg::OP_BEGIN_RD, i2cee_pkg::SUBADDR_W'($urandom()), 5'd2, 5);
   endtask

   task automatic change_random_setting();
      int value;
      case ($urandom_range(2))
         0: begin
            value = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 0 : 255)
                                             : $urandom_range(255);
            write_register(i2cee_pkg::CSR_DEVICE_ADDRESS, i2cee_pkg::CSR_DATA_W'(value));
         end
         1: write_register(i2cee_pkg::CSR_ADDRESS_BYTES,
                           i2cee_pkg::CSR_DATA_W'($urandom_range(3)));
         default: begin
            value = ($urandom_range(9) == 0) ? 1023 : $urandom_range(0, 5);
            write_register(i2cee_pkg::CSR_RETRY_LIMIT, i2cee_pkg::CSR_DATA_W'(value));
            nak_percent = (value > 8) ? 5 : 35;
         end
      endcase
   endtask

   // Mostly short, well-formed transfers with stray words and setting changes.
   task automatic test_random_traffic();
      int action;
      int count;
      int len;
      counting_random = 1'b1;
      random_words    = 0;
      while (random_words < RANDOM_WORDS) begin
         steady_flow = (random_words >= 300 && random_words < 500);
         action = $urandom_range(99);
         if (action < 8) begin
            change_random_setting();
         end else if (action < 18) begin
            repeat ($urandom_range(1, 3))
               send_word(random_word(($urandom_range(1) == 0) ? i2cee_pkg::OP_TICK
                                                              : i2cee_pkg::OP_PUSH));
         end else if (action < 58) begin
            count = ($urandom_range(19) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
            repeat (count) push_byte(i2cee_pkg::BYTE_W'($urandom()));
            len = ($urandom_range(19) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
            // Never send a queue entry that was not written since reset.
            if ((len > PAGE_BYTES ? PAGE_BYTES : len) > m_queue_filled) len = m_queue_filled;
            run_transfer(i2cee_pkg::OP_BEGIN_WR, i2cee_pkg::SUBADDR_W'($urandom()),
                         i2cee_pkg::LEN_W'(len), 3);
         end else begin
            len = ($urandom_range(29) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
            run_transfer(i2cee_pkg::OP_BEGIN_RD, i2cee_pkg::SUBADDR_W'($urandom()),
                         i2cee_pkg::LEN_W'(len), 3);
         end
      end
      steady_flow     = 1'b0;
      counting_random = 1'b0;
   endtask

   // Main sequence.
   initial begin
      mismatches      = 0;
      cycle_count     = 0;
      random_words    = 0;
      counting_random = 1'b0;
      steady_flow     = 1'b0;
      forced_naks     = 0;
      nak_percent     = 0;
      reset_bus_model();
      reset                  <= 1'b1;
      csr_wr_en              <= 1'b0;
      csr_index              <= '0;
      csr_wdata              <= '0;
      req_ch.valid           <= 1'b0;
      req_ch.op              <= i2cee_pkg::OP_TICK;
      req_ch.sda_in          <= 1'b1;
      req_ch.sub_address     <= '0;
      req_ch.transfer_length <= '0;
      req_ch.data_byte       <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_ticks();
      test_page_write();
      test_busy_commands();
      test_reads();
      test_address_widths();
      test_address_retries();
      test_back_pressure();
      test_random_traffic();

      wait_for_bus_words();
      if (mismatches == 0 && awaited_bus_words.size() == 0) begin
         $display("i2c_eeprom_transfer_master verification clean");
      end else begin
         $display("i2c_eeprom_transfer_master verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/i2cee_pkg.sv
rtl/core/i2cee_channels.sv
rtl/core/i2cee_queue.sv
rtl/core/i2cee_ctrl.sv
rtl/core/i2c_eeprom_transfer_master.sv
tb/i2c_eeprom_transfer_master_tb.sv
